// File: rtl/fcmv_pkg.sv
// Shared types, codes and helpers for the framed CBOR map validator.
`default_nettype none
package fcmv_pkg;

  localparam int unsigned KEY_BYTES_DEFAULT = 32;

  localparam logic [31:0] BUFFER_LENGTH_RESET = 32'd0;
  localparam logic [31:0] MAX_RECORD_RESET    = 32'd1048576;
  localparam logic [7:0]  FIELD_COUNT_RESET   = 8'd11;

  // register indexes
  localparam logic [1:0] REG_BUFFER_LENGTH = 2'd0;
  localparam logic [1:0] REG_MAX_RECORD    = 2'd1;
  localparam logic [1:0] REG_FIELD_COUNT   = 2'd2;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_SHORT       = 4'd1,
    ST_QUOTA       = 4'd2,
    ST_TORN        = 4'd3,
    ST_MAP_TYPE    = 4'd4,
    ST_BAD_WIDTH   = 4'd5,
    ST_NONSHORTEST = 4'd6,
    ST_COUNT       = 4'd7,
    ST_KEY         = 4'd8,
    ST_TRUNCATED   = 4'd9,
    ST_LENGTH      = 4'd10,
    ST_UTF8        = 4'd11,
    ST_TYPE        = 4'd12,
    ST_ORDER       = 4'd13,
    ST_TRAILING    = 4'd14,
    ST_KEY_LONG    = 4'd15
  } status_t;

  typedef enum logic [8:0] {
    PH_PREFIX   = 9'b000000001,
    PH_MAP_HEAD = 9'b000000010,
    PH_MAP_ARG  = 9'b000000100,
    PH_KEY_HEAD = 9'b000001000,
    PH_KEY_ARG  = 9'b000010000,
    PH_KEY_TEXT = 9'b000100000,
    PH_VAL_HEAD = 9'b001000000,
    PH_VAL_ARG  = 9'b010000000,
    PH_VAL_STR  = 9'b100000000
  } phase_t;

  typedef enum logic [1:0] {
    CMP_EQ = 2'd0,
    CMP_LT = 2'd1,
    CMP_GT = 2'd2
  } cmp_t;

  localparam logic [2:0] MAJOR_UINT  = 3'd0;
  localparam logic [2:0] MAJOR_BYTES = 3'd2;
  localparam logic [2:0] MAJOR_TEXT  = 3'd3;
  localparam logic [2:0] MAJOR_MAP   = 3'd5;

  localparam logic [4:0] AI_ONE_BYTE   = 5'd24;
  localparam logic [4:0] AI_EIGHT_BYTE = 5'd27;

  typedef struct packed {
    status_t     status;
    logic [31:0] record_count;
    logic [31:0] byte_offset;
    logic        final_res;
  } result_t;

  // UTF-8 decoder step: bit 3 flags a bad sequence, bits 2:0 the next state
  function automatic logic [3:0] utf8_next(input logic [2:0] s, input logic [7:0] b);
    logic cont;
    logic [3:0] r;
    cont = (b >= 8'h80) && (b <= 8'hbf);
    r = 4'b1000;
    case (s)
      3'd0: begin
        if (b < 8'h80) r = 4'd0;
        else if (b >= 8'hc2 && b <= 8'hdf) r = 4'd1;
        else if (b == 8'he0) r = 4'd4;
        else if (b == 8'hed) r = 4'd5;
        else if (b >= 8'he1 && b <= 8'hef) r = 4'd2;
        else if (b == 8'hf0) r = 4'd6;
        else if (b >= 8'hf1 && b <= 8'hf3) r = 4'd3;
        else if (b == 8'hf4) r = 4'd7;
      end
      3'd1: if (cont) r = 4'd0;
      3'd2: if (cont) r = 4'd1;
      3'd3: if (cont) r = 4'd2;
      3'd4: if (b >= 8'ha0 && b <= 8'hbf) r = 4'd1;
      3'd5: if (b >= 8'h80 && b <= 8'h9f) r = 4'd1;
      3'd6: if (b >= 8'h90 && b <= 8'hbf) r = 4'd2;
      default: if (b >= 8'h80 && b <= 8'h8f) r = 4'd2;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/fcmv_key_mem.sv
// Two-bank key store: current key written to one bank, previous key read from the other.
`default_nettype none
module fcmv_key_mem
  import fcmv_pkg::*;
#(
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEFAULT,
  localparam int unsigned IW = $clog2(KEY_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic          wr_bank,
  input  wire logic [IW-1:0] wr_idx,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_bank,
  input  wire logic [IW-1:0] rd_idx,
  output logic      [7:0]    rd_data
);

  localparam int unsigned DEPTH = 2 ** (IW + 1);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[{wr_bank, wr_idx}] <= wr_data;
  end

  // a byte written to the address being read is passed straight through to rd_data
  always_ff @(posedge clk) begin
    if (wr_en && wr_bank == rd_bank && wr_idx == rd_idx) rd_data <= wr_data;
    else rd_data <= mem[{rd_bank, rd_idx}];
  end

endmodule
`default_nettype wire

// File: rtl/fcmv_out_buf.sv
// Result output register with a skid stage.
`default_nettype none
module fcmv_out_buf
  import fcmv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/framed_cbor_map_validator_top.sv
// Top level of the framed CBOR map validator: byte parser, key store and result buffer.
//
//  channel  direction  handshake            payload
//  input    in         in_valid / in_stall  data_byte
//  result   out        out_valid/out_stall  status, record_count, byte_offset, final_res
//  config   in         cfg_write            cfg_index, cfg_data
//
// One byte a cycle unless in_stall; its result is registered in the output register or,
// if that is held, the skid stage. The previous-key byte is fetched from the key store
// ahead, addressed from the parser's next state, so consecutive key bytes need no wait.
// Reset (synchronous) and a buffer_length write restart parsing; no clearing pass.
// in_stall rises only when both the output register and the skid stage hold results.
`default_nettype none
module framed_cbor_map_validator_top
  import fcmv_pkg::*;
#(
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       status,
  output logic [31:0]      record_count,
  output logic [31:0]      byte_offset,
  output logic             final_res,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned IW = $clog2(KEY_BYTES);
  localparam int unsigned LW = $clog2(KEY_BYTES + 1);

  logic [31:0] buffer_length, max_record_bytes;
  logic [7:0]  field_count;

  phase_t      phase, phase_next;
  logic [63:0] prefix_shift, prefix_shift_next;
  logic [31:0] buffer_left, buffer_left_next;
  logic [31:0] body_left, body_left_next;
  logic [63:0] head_value, head_value_next;
  logic [7:0]  head_info, head_info_next;
  logic [3:0]  head_bytes_left, head_bytes_left_next;
  logic [31:0] string_left, string_left_next;
  logic [7:0]  entry_index, entry_index_next;
  logic [2:0]  utf8_state, utf8_state_next;
  logic [LW-1:0] current_key_len, current_key_len_next;
  logic [LW-1:0] previous_key_len, previous_key_len_next;
  cmp_t        compare_state, compare_state_next;
  logic [31:0] records_done, records_done_next;
  logic [31:0] offset_count, offset_count_next;
  logic        halted, halted_next;
  logic        key_bank, key_bank_next;

  logic        in_accept, active;
  logic        failed, rec_ok;
  status_t     fail_code;
  logic        go_keylen, go_keyend, go_valdone, go_valend, go_mapdone, go_next;
  logic        arg_more, arg_bad;
  logic [63:0] hv;
  logic [4:0]  ai;
  logic [3:0]  hb, u8;
  logic [63:0] arg_min;
  logic [31:0] limit, key_pos, rd_pos;
  logic [7:0]  prev_byte;
  logic        mem_we;
  logic [2:0]  major;
  result_t     res;
  logic        res_push;

  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length    <= BUFFER_LENGTH_RESET;
      max_record_bytes <= MAX_RECORD_RESET;
      field_count      <= FIELD_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BUFFER_LENGTH: buffer_length    <= cfg_data;
        REG_MAX_RECORD:    max_record_bytes <= cfg_data;
        REG_FIELD_COUNT:   field_count      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign key_pos = 32'(current_key_len) - string_left;

  always_comb begin
    phase_next            = phase;
    prefix_shift_next     = prefix_shift;
    buffer_left_next      = buffer_left;
    body_left_next        = body_left;
    head_value_next       = head_value;
    head_info_next        = head_info;
    head_bytes_left_next  = head_bytes_left;
    string_left_next      = string_left;
    entry_index_next      = entry_index;
    utf8_state_next       = utf8_state;
    current_key_len_next  = current_key_len;
    previous_key_len_next = previous_key_len;
    compare_state_next    = compare_state;
    records_done_next     = records_done;
    offset_count_next     = offset_count;
    halted_next           = halted;
    key_bank_next         = key_bank;
    failed = 1'b0; fail_code = ST_OK; rec_ok = 1'b0;
    go_keylen = 1'b0; go_keyend = 1'b0; go_valdone = 1'b0;
    go_valend = 1'b0; go_mapdone = 1'b0; go_next = 1'b0;
    arg_more = 1'b0; arg_bad = 1'b0; mem_we = 1'b0;
    hv = 64'd0; hb = 4'd0; u8 = 4'd0; arg_min = 64'd0;
    ai = data_byte[4:0];
    major = head_info[7:5];
    limit = (max_record_bytes >= 32'd8) ? max_record_bytes - 32'd8 : 32'd0;
    active = in_accept && !halted && buffer_left != 32'd0;

    if (active) begin
      offset_count_next = offset_count + 32'd1;
      buffer_left_next  = buffer_left - 32'd1;
      if (phase == PH_PREFIX) begin
        if (head_bytes_left == 4'd0 && buffer_left < 32'd8) begin
          failed = 1'b1; fail_code = ST_SHORT;
        end else begin
          hv = (head_bytes_left == 4'd0) ? {56'd0, data_byte}
                                         : {prefix_shift[55:0], data_byte};
          prefix_shift_next    = hv;
          head_bytes_left_next = head_bytes_left + 4'd1;
          if (head_bytes_left == 4'd7) begin
            head_bytes_left_next = 4'd0;
            if (hv == 64'd0 || hv > {32'd0, limit}) begin
              failed = 1'b1; fail_code = ST_QUOTA;
            end else if (hv > {32'd0, buffer_left_next}) begin
              failed = 1'b1; fail_code = ST_TORN;
            end else begin
              body_left_next   = hv[31:0];
              entry_index_next = 8'd0;
              phase_next       = PH_MAP_HEAD;
            end
          end
        end
      end else begin
        body_left_next = body_left - {31'd0, body_left != 32'd0};
        // argument handling shared by the head and argument phases
        if (phase == PH_MAP_HEAD || phase == PH_KEY_HEAD || phase == PH_VAL_HEAD) begin
          head_info_next  = data_byte;
          head_value_next = 64'd0;
          if (ai < AI_ONE_BYTE) begin
            head_value_next = {59'd0, ai};
          end else if (ai <= AI_EIGHT_BYTE) begin
            head_bytes_left_next = 4'd1 << ai[1:0];
            arg_more = 1'b1;
          end else begin
            arg_bad = 1'b1;
          end
        end else if (phase == PH_MAP_ARG || phase == PH_KEY_ARG || phase == PH_VAL_ARG) begin
          hv = {head_value[55:0], data_byte};
          head_value_next = hv;
          hb = (head_bytes_left != 4'd0) ? head_bytes_left - 4'd1 : 4'd0;
          head_bytes_left_next = hb;
          case (head_info[1:0])
            2'd0:    arg_min = 64'd24;
            2'd1:    arg_min = 64'd256;
            2'd2:    arg_min = 64'd65536;
            default: arg_min = 64'h1_0000_0000;
          endcase
          if (hb != 4'd0) arg_more = 1'b1;
          else if (head_info[4:0] >= AI_ONE_BYTE && head_info[4:0] <= AI_EIGHT_BYTE &&
                   hv < arg_min) arg_bad = 1'b1;
        end

        unique case (phase)
          PH_MAP_HEAD: begin
            if (data_byte[7:5] != MAJOR_MAP) begin
              failed = 1'b1; fail_code = ST_MAP_TYPE;
            end else if (arg_bad) begin
              failed = 1'b1; fail_code = ST_BAD_WIDTH;
            end else if (arg_more) begin
              phase_next = PH_MAP_ARG;
              if (body_left_next == 32'd0) begin
                failed = 1'b1; fail_code = ST_TRUNCATED;
              end
            end else go_mapdone = 1'b1;
          end
          PH_MAP_ARG: begin
            if (arg_more) begin
              if (body_left_next == 32'd0) begin
                failed = 1'b1; fail_code = ST_TRUNCATED;
              end
            end else if (arg_bad) begin
              failed = 1'b1; fail_code = ST_NONSHORTEST;
            end else go_mapdone = 1'b1;
          end
          PH_KEY_HEAD: begin
            if (data_byte[7:5] != MAJOR_TEXT || arg_bad) begin
              failed = 1'b1; fail_code = ST_KEY;
            end else if (arg_more) begin
              phase_next = PH_KEY_ARG;
              if (body_left_next == 32'd0) begin
                failed = 1'b1; fail_code = ST_KEY;
              end
            end else go_keylen = 1'b1;
          end
          PH_KEY_ARG: begin
            if (arg_more) begin
              if (body_left_next == 32'd0) begin
                failed = 1'b1; fail_code = ST_KEY;
              end
            end else if (arg_bad) begin
              failed = 1'b1; fail_code = ST_KEY;
            end else go_keylen = 1'b1;
          end
          PH_KEY_TEXT: begin
            mem_we = 1'b1;
            if (compare_state == CMP_EQ && key_pos < 32'(previous_key_len)) begin
              if (prev_byte < data_byte) compare_state_next = CMP_LT;
              else if (prev_byte > data_byte) compare_state_next = CMP_GT;
            end
            u8 = utf8_next(utf8_state, data_byte);
            utf8_state_next = u8[2:0];
            if (u8[3]) begin
              failed = 1'b1; fail_code = ST_KEY;
            end else begin
              string_left_next = string_left - {31'd0, string_left != 32'd0};
              if (string_left_next == 32'd0) go_keyend = 1'b1;
            end
          end
          PH_VAL_HEAD: begin
            if (arg_bad) begin
              failed = 1'b1; fail_code = ST_BAD_WIDTH;
            end else if (arg_more) begin
              phase_next = PH_VAL_ARG;
              if (body_left_next == 32'd0) begin
                failed = 1'b1; fail_code = ST_TRUNCATED;
              end
            end else go_valdone = 1'b1;
          end
          PH_VAL_ARG: begin
            if (arg_more) begin
              if (body_left_next == 32'd0) begin
                failed = 1'b1; fail_code = ST_TRUNCATED;
              end
            end else if (arg_bad) begin
              failed = 1'b1; fail_code = ST_NONSHORTEST;
            end else go_valdone = 1'b1;
          end
          PH_VAL_STR: begin
            if (major == MAJOR_TEXT) begin
              u8 = utf8_next(utf8_state, data_byte);
              utf8_state_next = u8[2:0];
            end
            if (u8[3]) begin
              failed = 1'b1; fail_code = ST_UTF8;
            end else begin
              string_left_next = string_left - {31'd0, string_left != 32'd0};
              if (string_left_next == 32'd0) begin
                if (major == MAJOR_TEXT && utf8_state_next != 3'd0) begin
                  failed = 1'b1; fail_code = ST_UTF8;
                end else go_valend = 1'b1;
              end
            end
          end
          default: begin
            failed = 1'b1; fail_code = ST_TRUNCATED;
          end
        endcase

        // follow-on steps once an argument or string is complete
        if (go_keylen) begin
          if (head_value_next > {32'd0, body_left_next}) begin
            failed = 1'b1; fail_code = ST_KEY;
          end else if (head_value_next > 64'(KEY_BYTES)) begin
            failed = 1'b1; fail_code = ST_KEY_LONG;
          end else begin
            current_key_len_next = head_value_next[LW-1:0];
            string_left_next     = head_value_next[31:0];
            utf8_state_next      = 3'd0;
            compare_state_next   = CMP_EQ;
            if (head_value_next == 64'd0) go_keyend = 1'b1;
            else phase_next = PH_KEY_TEXT;
          end
        end
        if (go_keyend) begin
          if (utf8_state_next != 3'd0) begin
            failed = 1'b1; fail_code = ST_KEY;
          end else if (entry_index != 8'd0 &&
                       !(previous_key_len < current_key_len_next ||
                         (previous_key_len == current_key_len_next &&
                          compare_state_next == CMP_LT))) begin
            failed = 1'b1; fail_code = ST_ORDER;
          end else begin
            previous_key_len_next = current_key_len_next;
            key_bank_next = ~key_bank;
            phase_next = PH_VAL_HEAD;
            if (body_left_next == 32'd0) begin
              failed = 1'b1; fail_code = ST_TRUNCATED;
            end
          end
        end
        if (go_valdone) begin
          if (head_info_next[7:5] == MAJOR_UINT) go_valend = 1'b1;
          else if (head_value_next > {32'd0, body_left_next}) begin
            failed = 1'b1; fail_code = ST_LENGTH;
          end else if (head_info_next[7:5] != MAJOR_BYTES &&
                       head_info_next[7:5] != MAJOR_TEXT) begin
            failed = 1'b1; fail_code = ST_TYPE;
          end else begin
            string_left_next = head_value_next[31:0];
            utf8_state_next  = 3'd0;
            if (head_value_next == 64'd0) go_valend = 1'b1;
            else phase_next = PH_VAL_STR;
          end
        end
        if (go_valend) begin
          entry_index_next = entry_index + 8'd1;
          go_next = 1'b1;
        end
        if (go_mapdone) begin
          if (head_value_next != {56'd0, field_count}) begin
            failed = 1'b1; fail_code = ST_COUNT;
          end else go_next = 1'b1;
        end
        if (go_next) begin
          if (entry_index_next >= field_count) begin
            if (body_left_next == 32'd0) begin
              rec_ok = 1'b1;
              if (records_done != 32'hffff_ffff) records_done_next = records_done + 32'd1;
              if (buffer_left_next == 32'd0) halted_next = 1'b1;
              phase_next = PH_PREFIX;
              head_bytes_left_next = 4'd0;
            end else begin
              failed = 1'b1; fail_code = ST_TRAILING;
            end
          end else begin
            phase_next = PH_KEY_HEAD;
            if (body_left_next == 32'd0) begin
              failed = 1'b1; fail_code = ST_KEY;
            end
          end
        end
      end
      if (failed) halted_next = 1'b1;
    end

    if (cfg_write && cfg_index == REG_BUFFER_LENGTH) begin
      phase_next            = PH_PREFIX;
      prefix_shift_next     = 64'd0;
      buffer_left_next      = cfg_data;
      body_left_next        = 32'd0;
      head_value_next       = 64'd0;
      head_info_next        = 8'd0;
      head_bytes_left_next  = 4'd0;
      string_left_next      = 32'd0;
      entry_index_next      = 8'd0;
      utf8_state_next       = 3'd0;
      current_key_len_next  = '0;
      previous_key_len_next = '0;
      compare_state_next    = CMP_EQ;
      records_done_next     = 32'd0;
      offset_count_next     = 32'd0;
      halted_next           = 1'b0;
    end
  end

  assign res_push         = active && (failed || rec_ok);
  assign res.status       = failed ? fail_code : ST_OK;
  assign res.record_count = records_done_next;
  assign res.byte_offset  = offset_count;
  assign res.final_res    = failed ? 1'b1 : (buffer_left_next == 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_PREFIX;
      prefix_shift     <= 64'd0;
      buffer_left      <= BUFFER_LENGTH_RESET;
      body_left        <= 32'd0;
      head_value       <= 64'd0;
      head_info        <= 8'd0;
      head_bytes_left  <= 4'd0;
      string_left      <= 32'd0;
      entry_index      <= 8'd0;
      utf8_state       <= 3'd0;
      current_key_len  <= '0;
      previous_key_len <= '0;
      compare_state    <= CMP_EQ;
      records_done     <= 32'd0;
      offset_count     <= 32'd0;
      halted           <= 1'b0;
      key_bank         <= 1'b0;
    end else begin
      phase            <= phase_next;
      prefix_shift     <= prefix_shift_next;
      buffer_left      <= buffer_left_next;
      body_left        <= body_left_next;
      head_value       <= head_value_next;
      head_info        <= head_info_next;
      head_bytes_left  <= head_bytes_left_next;
      string_left      <= string_left_next;
      entry_index      <= entry_index_next;
      utf8_state       <= utf8_state_next;
      current_key_len  <= current_key_len_next;
      previous_key_len <= previous_key_len_next;
      compare_state    <= compare_state_next;
      records_done     <= records_done_next;
      offset_count     <= offset_count_next;
      halted           <= halted_next;
      key_bank         <= key_bank_next;
    end
  end

  // fetch the previous-key byte for the position the next key byte will take
  assign rd_pos = 32'(current_key_len_next) - string_left_next;

  fcmv_key_mem #(.KEY_BYTES(KEY_BYTES)) u_key_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_bank (key_bank),
    .wr_idx  (key_pos[IW-1:0]),
    .wr_data (data_byte),
    .rd_bank (~key_bank_next),
    .rd_idx  (rd_pos[IW-1:0]),
    .rd_data (prev_byte)
  );

  result_t out_data;

  fcmv_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign status       = out_data.status;
  assign record_count = out_data.record_count;
  assign byte_offset  = out_data.byte_offset;
  assign final_res    = out_data.final_res;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid) else $error("skid stage holds a request with output empty");

  a_no_result_halted: assert property (@(posedge clk) disable iff (rst)
    halted |-> !res_push) else $error("result produced after parsing stopped");

  a_key_len_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_KEY_TEXT) |-> (32'(current_key_len) <= 32'(KEY_BYTES) &&
                                key_pos < 32'(KEY_BYTES)))
    else $error("key byte position outside key store");

  a_offset_step: assert property (@(posedge clk) disable iff (rst)
    (active && !cfg_write) |=> offset_count == $past(offset_count) + 32'd1)
    else $error("byte offset did not advance");

endmodule
`default_nettype wire

// File: tb/framed_cbor_map_validator_top_test.sv
// Self-checking testbench for the framed CBOR map validator: directed records, then random buffers.
`default_nettype none
module framed_cbor_map_validator_top_test;
  import fcmv_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  status;
  logic [31:0] record_count;
  logic [31:0] byte_offset;
  logic        final_res;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  framed_cbor_map_validator_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .record_count(record_count),
    .byte_offset(byte_offset), .final_res(final_res),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int unsigned KEY_MAX = 32;

  typedef struct packed {
    logic [31:0]  blen;
    logic [31:0]  maxrec;
    logic [7:0]   fc;
    logic [4:0]   n;
    logic [127:0] bytes;   // right-aligned, first byte highest
    status_t      st;
    logic         none;    // buffer gives no result at all
  } dir_case_t;

  // predictor state
  logic [31:0] p_blen, p_maxrec;
  logic [7:0]  p_fc;
  phase_t      p_phase;
  logic [63:0] p_prefix, p_hval;
  logic [7:0]  p_hinfo;
  int unsigned p_hleft;
  logic [31:0] p_bufleft, p_bodyleft, p_strleft, p_recs, p_offs;
  logic [7:0]  p_entry;
  logic [7:0]  p_utf;
  logic [7:0]  p_cur [KEY_MAX];
  logic [7:0]  p_prev [KEY_MAX];
  int unsigned p_curlen, p_prevlen;
  cmp_t        p_cmp;
  bit          p_halt;

  result_t     pending_status [$];
  result_t     want;
  logic [7:0]  stream [$];
  logic [7:0]  body_q [$];
  int          errors;
  int          counted_items;
  bit          gaps_on;
  bit          seen_result;
  logic [3:0]  last_status;
  dir_case_t   directed_cases [0:19];

  always #1 clk = ~clk;

  function automatic void restart_parse();
    p_phase = PH_PREFIX;
    p_prefix = '0;
    p_bufleft = p_blen;
    p_bodyleft = '0;
    p_hval = '0;
    p_hinfo = '0;
    p_hleft = 0;
    p_strleft = '0;
    p_entry = '0;
    p_utf = '0;
    for (int i = 0; i < KEY_MAX; i++) begin
      p_cur[i] = '0;
      p_prev[i] = '0;
    end
    p_curlen = 0;
    p_prevlen = 0;
    p_cmp = CMP_EQ;
    p_recs = '0;
    p_offs = '0;
    p_halt = 0;
  endfunction

  function automatic void post(status_t s, logic [31:0] off, logic fin);
    pending_status.push_back('{status: s, record_count: p_recs, byte_offset: off,
                               final_res: fin});
  endfunction

  function automatic void fail(status_t s, logic [31:0] off);
    p_halt = 1;
    post(s, off, 1'b1);
  endfunction

  function automatic int start_arg(logic [4:0] ai);
    p_hval = '0;
    if (ai < 24) begin
      p_hval = ai;
      return 0;
    end
    if (ai <= AI_EIGHT_BYTE) begin
      p_hleft = 1 << (ai - AI_ONE_BYTE);
      return 1;
    end
    return 2;
  endfunction

  // 0 more bytes, 1 done, 2 not shortest form
  function automatic int arg_byte(logic [7:0] b);
    logic [4:0]  ai;
    int unsigned w;
    logic [63:0] minimum;
    ai = p_hinfo[4:0];
    p_hval = {p_hval[55:0], b};
    if (p_hleft > 0) p_hleft--;
    if (p_hleft > 0) return 0;
    if (ai < AI_ONE_BYTE || ai > AI_EIGHT_BYTE) return 1;
    w = 1 << (ai - AI_ONE_BYTE);
    minimum = (w == 1) ? 64'd24 : (64'd1 << (8 * (w - 1)));
    return (p_hval < minimum) ? 2 : 1;
  endfunction

  function automatic logic [7:0] utf_step(logic [7:0] s, logic [7:0] b);
    case (s)
      8'd0: begin
        if (b < 8'h80) return 8'd0;
        if (b >= 8'hc2 && b <= 8'hdf) return 8'd1;
        if (b == 8'he0) return 8'd4;
        if (b == 8'hed) return 8'd5;
        if (b >= 8'he1 && b <= 8'hef) return 8'd2;
        if (b == 8'hf0) return 8'd6;
        if (b >= 8'hf1 && b <= 8'hf3) return 8'd3;
        if (b == 8'hf4) return 8'd7;
        return 8'hff;
      end
      8'd1: return (b >= 8'h80 && b <= 8'hbf) ? 8'd0 : 8'hff;
      8'd2: return (b >= 8'h80 && b <= 8'hbf) ? 8'd1 : 8'hff;
      8'd3: return (b >= 8'h80 && b <= 8'hbf) ? 8'd2 : 8'hff;
      8'd4: return (b >= 8'ha0 && b <= 8'hbf) ? 8'd1 : 8'hff;
      8'd5: return (b >= 8'h80 && b <= 8'h9f) ? 8'd1 : 8'hff;
      8'd6: return (b >= 8'h90 && b <= 8'hbf) ? 8'd2 : 8'hff;
      8'd7: return (b >= 8'h80 && b <= 8'h8f) ? 8'd2 : 8'hff;
      default: return 8'hff;
    endcase
  endfunction

  function automatic void record_ok(logic [31:0] off);
    logic fin;
    fin = (p_bufleft == 0);
    if (p_recs != 32'hffffffff) p_recs++;
    if (fin) p_halt = 1;
    p_phase = PH_PREFIX;
    p_hleft = 0;
    post(ST_OK, off, fin);
  endfunction

  function automatic void next_entry(logic [31:0] off);
    if (p_entry >= p_fc) begin
      if (p_bodyleft == 0) record_ok(off);
      else fail(ST_TRAILING, off);
      return;
    end
    p_phase = PH_KEY_HEAD;
    if (p_bodyleft == 0) fail(ST_KEY, off);
  endfunction

  function automatic void key_end(logic [31:0] off);
    if (p_utf != 0) begin
      fail(ST_KEY, off);
      return;
    end
    if (p_entry > 0 && !(p_prevlen < p_curlen ||
        (p_prevlen == p_curlen && p_cmp == CMP_LT))) begin
      fail(ST_ORDER, off);
      return;
    end
    p_prev = p_cur;
    p_prevlen = p_curlen;
    p_phase = PH_VAL_HEAD;
    if (p_bodyleft == 0) fail(ST_TRUNCATED, off);
  endfunction

  function automatic void key_len(logic [31:0] off);
    if (p_hval > p_bodyleft) begin
      fail(ST_KEY, off);
      return;
    end
    if (p_hval > KEY_MAX) begin
      fail(ST_KEY_LONG, off);
      return;
    end
    p_curlen = p_hval;
    p_strleft = p_curlen;
    p_utf = 0;
    p_cmp = CMP_EQ;
    if (p_strleft == 0) key_end(off);
    else p_phase = PH_KEY_TEXT;
  endfunction

  function automatic void value_end(logic [31:0] off);
    p_entry = p_entry + 8'd1;
    next_entry(off);
  endfunction

  function automatic void value_arg_done(logic [31:0] off);
    logic [2:0] major;
    major = p_hinfo[7:5];
    if (major == MAJOR_UINT) begin
      value_end(off);
      return;
    end
    if (p_hval > p_bodyleft) begin
      fail(ST_LENGTH, off);
      return;
    end
    if (major != MAJOR_BYTES && major != MAJOR_TEXT) begin
      fail(ST_TYPE, off);
      return;
    end
    p_strleft = p_hval;
    p_utf = 0;
    if (p_strleft == 0) value_end(off);
    else p_phase = PH_VAL_STR;
  endfunction

  function automatic void count_done(logic [31:0] off);
    if (p_hval != p_fc) fail(ST_COUNT, off);
    else next_entry(off);
  endfunction

  // returns 1 when the byte was consumed rather than dropped
  function automatic bit track_byte(logic [7:0] b);
    logic [31:0] off, left_before;
    logic [63:0] limit;
    int unsigned idx;
    int          r;
    bit          is_text;
    if (p_halt || p_bufleft == 0) return 0;
    off = p_offs;
    p_offs++;
    left_before = p_bufleft;
    p_bufleft--;
    if (p_phase == PH_PREFIX) begin
      if (p_hleft == 0) begin
        if (left_before < 8) begin
          fail(ST_SHORT, off);
          return 1;
        end
        p_prefix = '0;
      end
      p_prefix = {p_prefix[55:0], b};
      p_hleft++;
      if (p_hleft < 8) return 1;
      p_hleft = 0;
      limit = (p_maxrec >= 8) ? 64'(p_maxrec - 32'd8) : 64'd0;
      if (p_prefix == 0 || p_prefix > limit) fail(ST_QUOTA, off);
      else if (p_prefix > p_bufleft) fail(ST_TORN, off);
      else begin
        p_bodyleft = p_prefix[31:0];
        p_entry = '0;
        p_phase = PH_MAP_HEAD;
      end
      return 1;
    end
    if (p_bodyleft > 0) p_bodyleft--;
    case (p_phase)
      PH_MAP_HEAD: begin
        if (b[7:5] != MAJOR_MAP) fail(ST_MAP_TYPE, off);
        else begin
          p_hinfo = b;
          r = start_arg(b[4:0]);
          if (r == 2) fail(ST_BAD_WIDTH, off);
          else if (r == 1) begin
            p_phase = PH_MAP_ARG;
            if (p_bodyleft == 0) fail(ST_TRUNCATED, off);
          end else count_done(off);
        end
      end
      PH_MAP_ARG: begin
        r = arg_byte(b);
        if (r == 0) begin
          if (p_bodyleft == 0) fail(ST_TRUNCATED, off);
        end else if (r == 2) fail(ST_NONSHORTEST, off);
        else count_done(off);
      end
      PH_KEY_HEAD: begin
        if (b[7:5] != MAJOR_TEXT) fail(ST_KEY, off);
        else begin
          p_hinfo = b;
          r = start_arg(b[4:0]);
          if (r == 2) fail(ST_KEY, off);
          else if (r == 1) begin
            p_phase = PH_KEY_ARG;
            if (p_bodyleft == 0) fail(ST_KEY, off);
          end else key_len(off);
        end
      end
      PH_KEY_ARG: begin
        r = arg_byte(b);
        if (r == 0) begin
          if (p_bodyleft == 0) fail(ST_KEY, off);
        end else if (r == 2) fail(ST_KEY, off);
        else key_len(off);
      end
      PH_KEY_TEXT: begin
        idx = p_curlen - p_strleft;
        if (idx < KEY_MAX) begin
          p_cur[idx] = b;
          if (p_cmp == CMP_EQ && idx < p_prevlen) begin
            if (p_prev[idx] < b) p_cmp = CMP_LT;
            else if (p_prev[idx] > b) p_cmp = CMP_GT;
          end
        end
        p_utf = utf_step(p_utf, b);
        if (p_utf == 8'hff) fail(ST_KEY, off);
        else begin
          if (p_strleft > 0) p_strleft--;
          if (p_strleft == 0) key_end(off);
        end
      end
      PH_VAL_HEAD: begin
        p_hinfo = b;
        r = start_arg(b[4:0]);
        if (r == 2) fail(ST_BAD_WIDTH, off);
        else if (r == 1) begin
          p_phase = PH_VAL_ARG;
          if (p_bodyleft == 0) fail(ST_TRUNCATED, off);
        end else value_arg_done(off);
      end
      PH_VAL_ARG: begin
        r = arg_byte(b);
        if (r == 0) begin
          if (p_bodyleft == 0) fail(ST_TRUNCATED, off);
        end else if (r == 2) fail(ST_NONSHORTEST, off);
        else value_arg_done(off);
      end
      PH_VAL_STR: begin
        is_text = (p_hinfo[7:5] == MAJOR_TEXT);
        if (is_text) begin
          p_utf = utf_step(p_utf, b);
          if (p_utf == 8'hff) begin
            fail(ST_UTF8, off);
            return 1;
          end
        end
        if (p_strleft > 0) p_strleft--;
        if (p_strleft == 0) begin
          if (is_text && p_utf != 0) fail(ST_UTF8, off);
          else value_end(off);
        end
      end
      default: fail(ST_TRUNCATED, off);
    endcase
    return 1;
  endfunction

  // ---- stimulus builders ----
  function automatic void push_head(logic [2:0] major, logic [63:0] v);
    if (v < 24) body_q.push_back({major, v[4:0]});
    else if (v < 64'h100) begin
      body_q.push_back({major, AI_ONE_BYTE});
      body_q.push_back(v[7:0]);
    end else if (v < 64'h10000) begin
      body_q.push_back({major, 5'd25});
      for (int i = 1; i >= 0; i--) body_q.push_back(v[8*i +: 8]);
    end else if (v < 64'h100000000) begin
      body_q.push_back({major, 5'd26});
      for (int i = 3; i >= 0; i--) body_q.push_back(v[8*i +: 8]);
    end else begin
      body_q.push_back({major, AI_EIGHT_BYTE});
      for (int i = 7; i >= 0; i--) body_q.push_back(v[8*i +: 8]);
    end
  endfunction

  // exactly n bytes of well-formed UTF-8, edge leads included
  function automatic void add_text(int n);
    int         w;
    logic [7:0] lead;
    while (n > 0) begin
      w = $urandom_range(1, (n < 4) ? n : 4);
      case (w)
        1: body_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
        2: begin
          body_q.push_back(8'($urandom_range(8'hc2, 8'hdf)));
          body_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
        end
        3: begin
          lead = $urandom_range(8'he0, 8'hef);
          body_q.push_back(lead);
          if (lead == 8'he0) body_q.push_back(8'($urandom_range(8'ha0, 8'hbf)));
          else if (lead == 8'hed) body_q.push_back(8'($urandom_range(8'h80, 8'h9f)));
          else body_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
          body_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
        end
        default: begin
          lead = $urandom_range(8'hf0, 8'hf4);
          body_q.push_back(lead);
          if (lead == 8'hf0) body_q.push_back(8'($urandom_range(8'h90, 8'hbf)));
          else if (lead == 8'hf4) body_q.push_back(8'($urandom_range(8'h80, 8'h8f)));
          else body_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
          body_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
          body_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
        end
      endcase
      n -= w;
    end
  endfunction

  // one well-formed record into stream; returns its body length
  function automatic int add_record(logic [7:0] fc);
    bit          by_length;
    int          klen, n;
    int unsigned stem_len;
    logic [7:0]  stem [3];
    logic [63:0] v, blen;
    body_q.delete();
    by_length = $urandom_range(1);
    klen = $urandom_range(0, 2);
    stem_len = $urandom_range(0, 3);
    foreach (stem[i]) stem[i] = $urandom_range(8'h30, 8'h7a);
    push_head(MAJOR_MAP, fc);
    for (int i = 0; i < fc; i++) begin
      if (by_length) begin
        push_head(MAJOR_TEXT, klen);
        add_text(klen);
        klen += $urandom_range(1, 3);
        if (klen > KEY_MAX) klen = KEY_MAX;
      end else begin
        // same-length keys ordered by their last byte
        push_head(MAJOR_TEXT, stem_len + 1);
        for (int j = 0; j < stem_len; j++) body_q.push_back(stem[j]);
        body_q.push_back(8'h41 + 8'(i));
      end
      case ($urandom_range(2))
        0: begin
          case ($urandom_range(4))
            0: v = $urandom_range(0, 23);
            1: v = $urandom_range(0, 255);
            2: v = $urandom_range(0, 65535);
            3: v = $urandom;
            default: v = {$urandom, $urandom};
          endcase
          push_head(MAJOR_UINT, v);
        end
        1: begin
          n = $urandom_range(0, 6);
          push_head(MAJOR_TEXT, n);
          add_text(n);
        end
        default: begin
          n = $urandom_range(0, 6);
          push_head(MAJOR_BYTES, n);
          repeat (n) body_q.push_back(8'($urandom));
        end
      endcase
    end
    blen = body_q.size();
    for (int i = 7; i >= 0; i--) stream.push_back(blen[8*i +: 8]);
    foreach (body_q[i]) stream.push_back(body_q[i]);
    return body_q.size();
  endfunction

  // ---- bus tasks, entered and left at a falling edge ----
  task automatic write_regs(logic [31:0] blen, logic [31:0] maxrec, logic [7:0] fc);
    cfg_write <= 1'b1;
    cfg_index <= REG_MAX_RECORD;
    cfg_data <= maxrec;
    @(negedge clk);
    cfg_index <= REG_FIELD_COUNT;
    cfg_data <= {24'd0, fc};
    @(negedge clk);
    cfg_index <= REG_BUFFER_LENGTH;
    cfg_data <= blen;
    @(negedge clk);
    cfg_write <= 1'b0;
    p_maxrec = maxrec;
    p_fc = fc;
    p_blen = blen;
    restart_parse();
  endtask

  task automatic send_byte(logic [7:0] b);
    while (gaps_on && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    if (track_byte(b)) counted_items++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_buffer();
    int          nrec, body, maxbody, extra;
    logic [7:0]  fc;
    logic [31:0] maxrec, blen;
    stream.delete();
    maxbody = 0;
    case ($urandom_range(9))
      7, 8: fc = $urandom_range(5, 12);
      9: fc = $urandom_range(20, 30);
      default: fc = $urandom_range(0, 4);
    endcase
    nrec = $urandom_range(1, 3);
    repeat (nrec) begin
      body = add_record(fc);
      if (body > maxbody) maxbody = body;
    end
    if ($urandom_range(99) < 35)
      stream[$urandom_range(0, stream.size() - 1)] = $urandom;
    case ($urandom_range(7))
      0: maxrec = 32'hffffffff;
      1: maxrec = maxbody + 8;
      2: maxrec = maxbody + 7;
      3: maxrec = $urandom_range(9, 20);
      default: maxrec = MAX_RECORD_RESET;
    endcase
    case ($urandom_range(9))
      0: blen = (stream.size() > 5) ? stream.size() - $urandom_range(1, 5) : stream.size();
      1: blen = stream.size() + $urandom_range(1, 9);
      2: blen = 32'hffffffff;
      default: blen = stream.size();
    endcase
    extra = $urandom_range(0, 3);
    repeat (extra) stream.push_back(8'($urandom));
    write_regs(blen, maxrec, fc);
    foreach (stream[i]) send_byte(stream[i]);
    settle();
  endtask

  // ---- result checking ----
  always @(negedge clk) out_stall <= gaps_on && ($urandom_range(99) < 24);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_result <= 1'b1;
      last_status <= status;
      if (pending_status.size() == 0) begin
        $display("%0t: result with no request outstanding: status %0d offset %0d",
                 $time, status, byte_offset);
        errors++;
      end else begin
        want = pending_status.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, status);
          errors++;
        end
        if (record_count !== want.record_count) begin
          $display("%0t: record_count expected %0d got %0d", $time,
                   want.record_count, record_count);
          errors++;
        end
        if (byte_offset !== want.byte_offset) begin
          $display("%0t: byte_offset expected %0d got %0d", $time,
                   want.byte_offset, byte_offset);
          errors++;
        end
        if (final_res !== want.final_res) begin
          $display("%0t: final_res expected %0b got %0b", $time,
                   want.final_res, final_res);
          errors++;
        end
      end
    end
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    cfg_write = 1'b0;
    cfg_index = REG_BUFFER_LENGTH;
    cfg_data = '0;
    out_stall = 1'b0;
    errors = 0;
    counted_items = 0;
    gaps_on = 1'b1;
    seen_result = 1'b0;
    last_status = '0;
    p_blen = BUFFER_LENGTH_RESET;
    p_maxrec = MAX_RECORD_RESET;
    p_fc = FIELD_COUNT_RESET;
    restart_parse();

    //                   blen  maxrec        fc  n   bytes                       status
    directed_cases[0]  = '{32'd3,  MAX_RECORD_RESET, 8'd0, 5'd1,  128'h00, ST_SHORT, 1'b0};
    directed_cases[1]  = '{32'd0,  MAX_RECORD_RESET, 8'd0, 5'd2,  128'hffff, ST_OK, 1'b1};
    directed_cases[2]  = '{32'd8,  MAX_RECORD_RESET, 8'd0, 5'd8,  128'h00, ST_QUOTA, 1'b0};
    directed_cases[3]  = '{32'd9,  32'd0,            8'd0, 5'd8,  128'h01, ST_QUOTA, 1'b0};
    directed_cases[4]  = '{32'd9,  MAX_RECORD_RESET, 8'd0, 5'd8,  128'h05, ST_TORN, 1'b0};
    directed_cases[5]  = '{32'd9,  32'd9,            8'd0, 5'd9,  128'h01a0, ST_OK, 1'b0};
    directed_cases[6]  = '{32'd11, 32'hffffffff,     8'd1, 5'd11, 128'h03a16000, ST_OK, 1'b0};
    directed_cases[7]  = '{32'd9,  MAX_RECORD_RESET, 8'd0, 5'd9,  128'h0180, ST_MAP_TYPE, 1'b0};
    directed_cases[8]  = '{32'd10, MAX_RECORD_RESET, 8'd0, 5'd9,  128'h02bc, ST_BAD_WIDTH, 1'b0};
    directed_cases[9]  = '{32'd11, MAX_RECORD_RESET, 8'd0, 5'd10, 128'h03b801,
                           ST_NONSHORTEST, 1'b0};
    directed_cases[10] = '{32'd9,  MAX_RECORD_RESET, 8'd255, 5'd9, 128'h01a0, ST_COUNT, 1'b0};
    directed_cases[11] = '{32'd10, MAX_RECORD_RESET, 8'd1, 5'd10, 128'h02a101, ST_KEY, 1'b0};
    directed_cases[12] = '{32'd48, MAX_RECORD_RESET, 8'd1, 5'd11, 128'h28a17821,
                           ST_KEY_LONG, 1'b0};
    directed_cases[13] = '{32'd13, MAX_RECORD_RESET, 8'd1, 5'd13, 128'h05a16062c3ff,
                           ST_UTF8, 1'b0};
    directed_cases[14] = '{32'd11, MAX_RECORD_RESET, 8'd1, 5'd11, 128'h03a16020, ST_TYPE, 1'b0};
    directed_cases[15] = '{32'd11, MAX_RECORD_RESET, 8'd1, 5'd11, 128'h03a16041,
                           ST_LENGTH, 1'b0};
    directed_cases[16] = '{32'd15, MAX_RECORD_RESET, 8'd2, 5'd15, 128'h07a2616200616100,
                           ST_ORDER, 1'b0};
    directed_cases[17] = '{32'd10, MAX_RECORD_RESET, 8'd0, 5'd10, 128'h02a000,
                           ST_TRAILING, 1'b0};
    directed_cases[18] = '{32'd9,  MAX_RECORD_RESET, 8'd1, 5'd9,  128'h01a1, ST_KEY, 1'b0};
    directed_cases[19] = '{32'd10, MAX_RECORD_RESET, 8'd1, 5'd10, 128'h02a160,
                           ST_TRUNCATED, 1'b0};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_cases[c]) begin
      seen_result = 1'b0;
      write_regs(directed_cases[c].blen, directed_cases[c].maxrec, directed_cases[c].fc);
      for (int k = 0; k < directed_cases[c].n; k++)
        send_byte(directed_cases[c].bytes[8 * (directed_cases[c].n - 1 - k) +: 8]);
      settle();
      if (directed_cases[c].none ? seen_result
          : (!seen_result || last_status !== directed_cases[c].st)) begin
        $display("%0t: buffer %0d status expected %0d got %0d (result seen %0b)", $time, c,
                 directed_cases[c].st, last_status, seen_result);
        errors++;
      end
    end

    for (int phase_no = 0; counted_items < 600; phase_no++) begin
      gaps_on = !(phase_no >= 6 && phase_no < 14);   // a stretch at full rate
      random_buffer();
    end

    settle();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
